/* rtl/core/rlcb_pkg.sv */
// Shared types and constants for the RMS level capture buffer.
// No dependencies.
`timescale 1ns / 1ps

package rlcb_pkg;

  localparam int SAMPLE_W = 18;
  localparam int CNT_W    = 17;
  localparam int LEVEL_W  = 16;
  localparam int GAIN_W   = 8;
  localparam int RIDX_W   = 16;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_RST  = 8'd12;
  localparam logic [CNT_W-1:0]  LIMIT_RST = 17'd65536;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

endpackage

/* rtl/core/rlcb_level_unit.sv */
// Level computation: gain^2 * sum by shift-add, restoring divide by the
// sample count, then a two-bits-per-step square root. Uses rlcb_pkg.
`timescale 1ns / 1ps

module rlcb_level_unit import rlcb_pkg::*; #(
  parameter int SUM_W = 41,
  parameter int PC_W  = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUM_W-1:0]   sum_i,
  input  logic [PC_W-1:0]    n_i,
  input  logic [GAIN_W-1:0]  gain_i,
  output logic               done_o,
  output logic [LEVEL_W-1:0] level_o
);

  localparam int PW     = SUM_W + 2 * GAIN_W;
  localparam int STEP_W = $clog2(PW);
  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(2 * GAIN_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(PW - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(14);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_SQRT = 4'b1000
  } ustate_e;

  ustate_e                 st_q, st_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [2*GAIN_W-1:0]     g2_q, g2_d;
  logic [SUM_W-1:0]        src_q, src_d;
  logic [PC_W-1:0]         n_q, n_d;
  logic [PW-1:0]           dvd_q, dvd_d;
  logic [PC_W-1:0]         rem_q, rem_d;
  logic [14:0]             root_q, root_d;
  logic [15:0]             srem_q, srem_d;
  logic                    done_q, done_d;
  logic [LEVEL_W-1:0]      level_q, level_d;

  logic [PC_W:0]           div_sh;
  logic                    div_ge;
  logic [PW-1:0]           dvd_div;
  logic [17:0]             sq_sh, sq_trial;
  logic                    sq_ge;
  logic [14:0]             root_nx;

  always_comb begin
    div_sh   = {rem_q, dvd_q[PW-1]};
    div_ge   = div_sh >= {1'b0, n_q};
    dvd_div  = {dvd_q[PW-2:0], div_ge};
    sq_sh    = {srem_q, dvd_q[29:28]};
    sq_trial = {1'b0, root_q, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    root_nx  = {root_q[13:0], sq_ge};
  end

  always_comb begin
    st_d    = st_q;
    step_d  = step_q;
    g2_d    = g2_q;
    src_d   = src_q;
    n_d     = n_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    root_d  = root_q;
    srem_d  = srem_q;
    done_d  = 1'b0;
    level_d = level_q;
    case (st_q)
      U_IDLE: begin
        if (start_i) begin
          src_d  = sum_i;
          n_d    = n_i;
          g2_d   = (2*GAIN_W)'(gain_i) * (2*GAIN_W)'(gain_i);
          dvd_d  = '0;
          step_d = '0;
          st_d   = U_MUL;
        end
      end
      U_MUL: begin
        dvd_d  = {dvd_q[PW-2:0], 1'b0} + (g2_q[2*GAIN_W-1] ? PW'(src_q) : '0);
        g2_d   = {g2_q[2*GAIN_W-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == MUL_LAST) begin
          step_d = '0;
          rem_d  = '0;
          st_d   = U_DIV;
        end
      end
      U_DIV: begin
        rem_d  = div_ge ? PC_W'(div_sh - {1'b0, n_q}) : div_sh[PC_W-1:0];
        dvd_d  = dvd_div;
        step_d = step_q + 1'b1;
        if (step_q == DIV_LAST) begin
          step_d = '0;
          if (|dvd_div[PW-1:30]) begin
            level_d = FULL_SCALE;
            done_d  = 1'b1;
            st_d    = U_IDLE;
          end else begin
            root_d = '0;
            srem_d = '0;
            st_d   = U_SQRT;
          end
        end
      end
      U_SQRT: begin
        srem_d = sq_ge ? 16'(sq_sh - sq_trial) : sq_sh[15:0];
        root_d = root_nx;
        dvd_d  = {dvd_q[PW-3:0], 2'b00};
        step_d = step_q + 1'b1;
        if (step_q == SQRT_LAST) begin
          step_d  = '0;
          level_d = {1'b0, root_nx};
          done_d  = 1'b1;
          st_d    = U_IDLE;
        end
      end
      default: st_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= U_IDLE;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g2_q    <= g2_d;
    src_q   <= src_d;
    n_q     <= n_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    srem_q  <= srem_d;
    level_q <= level_d;
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule

/* rtl/core/rms_level_capture_buffer.sv */
// Top level: capture store, period accumulator, control and result register.
// Uses rlcb_pkg and rlcb_level_unit.
//
// channel | dir | handshake                    | beat
// --------+-----+------------------------------+-----------------------------------
// in      | in  | in_valid_i / in_ready_o      | operation, sample, period_end, read_index
// out     | out | out_valid_o / out_ready_i    | level .. start_error, one per input beat
// cfg     | in  | cfg_we_i                     | cfg_index_i, cfg_wdata_i
//
// Sample (no period end), start and stop: result loaded when the result register is free.
// Read: the result waits for the registered store read port.
// Period end: the result waits for the period sum and then the shift-add,
// bit-serial divide and square-root steps of the level unit.
// A new input beat is taken while a result waits; its own result then waits in turn.
// Reset clears all control state; the store needs no clearing pass.
`timescale 1ns / 1ps

module rms_level_capture_buffer import rlcb_pkg::*; #(
  parameter int CAPACITY   = 65536,
  parameter int MAX_PERIOD = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 operation_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       period_end_i,
  input  logic [RIDX_W-1:0]          read_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [LEVEL_W-1:0]         level_o,
  output logic                       level_updated_o,
  output logic signed [SAMPLE_W-1:0] read_data_o,
  output logic                       read_valid_o,
  output logic [CNT_W-1:0]           stored_total_o,
  output logic                       limit_hit_o,
  output logic                       capturing_o,
  output logic                       start_error_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i
);

  localparam int PC_W      = $clog2(MAX_PERIOD + 1);
  localparam int SUM_W     = 30 + PC_W;
  localparam int MEM_DEPTH = (CAPACITY < 65536) ? CAPACITY : 65536;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int LIM_MAX   = (CAPACITY < 131071) ? CAPACITY : 131071;
  localparam logic [CNT_W-1:0] LIM_MAX_C   = CNT_W'(LIM_MAX);
  localparam logic [CNT_W-1:0] MEM_DEPTH_C = CNT_W'(MEM_DEPTH);
  localparam logic [PC_W-1:0]  MAX_PER_C   = PC_W'(MAX_PERIOD);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_CALC = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e              st_q, st_d;
  logic [GAIN_W-1:0]   gain_q;
  logic [CNT_W-1:0]    limit_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic [PC_W-1:0]     nlat_q, nlat_d;
  logic [SUM_W-1:0]    sum_q, sum_d, sum_add;
  logic [30:0]         sq_q;
  logic                sq_vld_q, sq_vld_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic                act_q, act_d;
  logic                drop_q, drop_d;
  logic                res_upd_q, res_rv_q, res_serr_q;

  logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  logic                out_valid_q;
  logic [LEVEL_W-1:0]  out_level_q;
  logic                out_upd_q, out_rv_q, out_serr_q, out_limit_q, out_cap_q;
  logic [SAMPLE_W-1:0] out_rdata_q;
  logic [CNT_W-1:0]    out_total_q;

  op_e                 op;
  logic                acc, slot_free, load, direct, compute, clr_sum;
  logic                mem_we, mem_re, room, pc_room, rv_now, serr_now;
  logic [CNT_W-1:0]    lim;
  logic [PC_W-1:0]     pc_inc;
  logic [17:0]         abs_v;
  logic [15:0]         mag;
  logic                lu_done;
  logic [LEVEL_W-1:0]  lu_level;

  assign op         = op_e'(operation_i);
  assign in_ready_o = (st_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    lim     = (limit_q < LIM_MAX_C) ? limit_q : LIM_MAX_C;
    room    = cnt_q < lim;
    pc_room = pc_q < MAX_PER_C;
    pc_inc  = pc_room ? pc_q + 1'b1 : pc_q;
    abs_v   = sample_i[SAMPLE_W-1] ? 18'(-sample_i) : 18'(sample_i);
    mag     = (abs_v > 18'd32768) ? FULL_SCALE : abs_v[15:0];
    sum_add = sq_vld_q ? sum_q + SUM_W'(sq_q) : sum_q;
  end

  always_comb begin
    cnt_d    = cnt_q;
    pc_d     = pc_q;
    nlat_d   = nlat_q;
    level_d  = level_q;
    act_d    = act_q;
    drop_d   = drop_q;
    sq_vld_d = 1'b0;
    clr_sum  = 1'b0;
    compute  = 1'b0;
    rv_now   = 1'b0;
    serr_now = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    if (acc) begin
      case (op)
        OP_SAMPLE: begin
          if (act_q) begin
            sq_vld_d = pc_room;
            pc_d     = pc_inc;
            if (room) begin
              cnt_d  = cnt_q + 1'b1;
              mem_we = cnt_q < MEM_DEPTH_C;
            end else begin
              drop_d = 1'b1;
            end
            if (period_end_i) begin
              compute = 1'b1;
              nlat_d  = pc_inc;
              pc_d    = '0;
            end
          end
        end
        OP_START: begin
          if (act_q) begin
            serr_now = 1'b1;
          end else begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            level_d = '0;
            pc_d    = '0;
            act_d   = 1'b1;
            clr_sum = 1'b1;
          end
        end
        OP_STOP: begin
          act_d   = 1'b0;
          level_d = '0;
          pc_d    = '0;
          clr_sum = 1'b1;
        end
        OP_READ: begin
          mem_re = 1'b1;
          rv_now = {1'b0, read_index_i} < cnt_q;
        end
        default: ;
      endcase
    end
    if (lu_done) begin
      level_d = lu_level;
    end
    if (st_q == S_SUM) begin
      clr_sum = 1'b1;
    end
    sum_d = clr_sum ? '0 : sum_add;
  end

  assign direct = !compute && (op != OP_READ);
  assign load   = (acc && direct && slot_free) || ((st_q == S_DONE) && slot_free);

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (acc) begin
          if (compute) begin
            st_d = S_SUM;
          end else if (!direct || !slot_free) begin
            st_d = S_DONE;
          end
        end
      end
      S_SUM:  st_d = S_CALC;
      S_CALC: if (lu_done) st_d = S_DONE;
      S_DONE: if (slot_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  rlcb_level_unit #(
    .SUM_W (SUM_W),
    .PC_W  (PC_W)
  ) u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == S_SUM),
    .sum_i   (sum_add),
    .n_i     (nlat_q),
    .gain_i  (gain_q),
    .done_o  (lu_done),
    .level_o (lu_level)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= sample_i;
    end
    if (mem_re) begin
      rdata_q <= mem[read_index_i[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      gain_q      <= GAIN_RST;
      limit_q     <= LIMIT_RST;
      cnt_q       <= '0;
      pc_q        <= '0;
      sum_q       <= '0;
      sq_vld_q    <= 1'b0;
      level_q     <= '0;
      act_q       <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      pc_q     <= pc_d;
      sum_q    <= sum_d;
      sq_vld_q <= sq_vld_d && !clr_sum;
      level_q  <= level_d;
      act_q    <= act_d;
      drop_q   <= drop_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LEVEL_GAIN:   gain_q  <= cfg_wdata_i[GAIN_W-1:0];
          REG_SAMPLE_LIMIT: limit_q <= cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= 31'(32'(mag) * 32'(mag));
    nlat_q <= nlat_d;
    if (acc) begin
      res_upd_q  <= compute;
      res_rv_q   <= rv_now;
      res_serr_q <= serr_now;
    end
    if (load) begin
      out_level_q <= level_d;
      out_total_q <= cnt_d;
      out_limit_q <= drop_d;
      out_cap_q   <= act_d;
      out_upd_q   <= (st_q == S_DONE) && res_upd_q;
      out_rv_q    <= (st_q == S_DONE) && res_rv_q;
      out_serr_q  <= (st_q == S_DONE) ? res_serr_q : serr_now;
      out_rdata_q <= ((st_q == S_DONE) && res_rv_q) ? rdata_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign level_o         = out_level_q;
  assign level_updated_o = out_upd_q;
  assign read_data_o     = out_rdata_q;
  assign read_valid_o    = out_rv_q;
  assign stored_total_o  = out_total_q;
  assign limit_hit_o     = out_limit_q;
  assign capturing_o     = out_cap_q;
  assign start_error_o   = out_serr_q;

endmodule

/* rtl/core/rlcb_checker.sv */
// Port-level checks for the RMS level capture buffer, bound to the top level.
// Uses rlcb_pkg.
`timescale 1ns / 1ps

module rlcb_checker import rlcb_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [LEVEL_W-1:0]         level_o,
  input logic                       level_updated_o,
  input logic signed [SAMPLE_W-1:0] read_data_o,
  input logic                       read_valid_o,
  input logic                       capturing_o,
  input logic                       start_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_o))
    else $error("result beat dropped or changed while stalled");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_o <= FULL_SCALE)
    else $error("level above full scale");

  a_upd_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && level_updated_o |-> capturing_o && !read_valid_o && !start_error_o)
    else $error("level update outside an active capture");

  a_serr_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_error_o |-> capturing_o && !read_valid_o)
    else $error("start error while idle");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_data_o == '0)
    else $error("read data without a valid read");

endmodule

bind rms_level_capture_buffer rlcb_checker u_rlcb_checker (.*);

/* bench/tb.sv */
// Testbench for rms_level_capture_buffer: directed and random beats checked
// against an in-bench model of the level meter and capture store.
// Depends on rlcb_pkg and the rms_level_capture_buffer RTL.
`timescale 1ns / 1ps

module tb;
  import rlcb_pkg::*;

  localparam int STORE_DEPTH = 65536;
  localparam int PERIOD_CAP  = 1024;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_WAIT  = 200;

  typedef struct {
    logic [LEVEL_W-1:0]  level;
    logic                updated;
    logic [SAMPLE_W-1:0] rdata;
    logic                rvalid;
    logic [CNT_W-1:0]    total;
    logic                hit;
    logic                capturing;
    logic                serr;
  } meter_beat_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 operation_i = OP_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       period_end_i = 1'b0;
  logic [RIDX_W-1:0]          read_index_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [LEVEL_W-1:0]         level_o;
  logic                       level_updated_o;
  logic signed [SAMPLE_W-1:0] read_data_o;
  logic                       read_valid_o;
  logic [CNT_W-1:0]           stored_total_o;
  logic                       limit_hit_o;
  logic                       capturing_o;
  logic                       start_error_o;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = REG_LEVEL_GAIN;
  logic [CFG_W-1:0]           cfg_wdata_i = '0;

  rms_level_capture_buffer #(
    .CAPACITY  (STORE_DEPTH),
    .MAX_PERIOD(PERIOD_CAP)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .sample_i       (sample_i),
    .period_end_i   (period_end_i),
    .read_index_i   (read_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .level_o        (level_o),
    .level_updated_o(level_updated_o),
    .read_data_o    (read_data_o),
    .read_valid_o   (read_valid_o),
    .stored_total_o (stored_total_o),
    .limit_hit_o    (limit_hit_o),
    .capturing_o    (capturing_o),
    .start_error_o  (start_error_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // meter model state
  logic [SAMPLE_W-1:0] mtr_store [int];
  int                  mtr_count = 0;
  logic [63:0]         mtr_sum = '0;
  int                  mtr_period = 0;
  logic [LEVEL_W-1:0]  mtr_level = '0;
  bit                  mtr_active = 1'b0;
  bit                  mtr_dropped = 1'b0;
  logic [GAIN_W-1:0]   mtr_gain = GAIN_RST;
  int                  mtr_limit = int'(LIMIT_RST);

  meter_beat_t expected_beats [$];

  int send_idle_pct = 26;
  int recv_idle_pct = 70;
  int hold_cycles = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int n_items = 0;
  int n_counted = 0;
  int n_checked = 0;
  int n_updates = 0;
  int n_reads = 0;

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic meter_beat_t meter_step(input op_e op,
                                             input logic signed [SAMPLE_W-1:0] smp,
                                             input logic pend,
                                             input logic [RIDX_W-1:0] ridx);
    meter_beat_t bt;
    int          v;
    int          cap_lim;
    logic [63:0] mag;
    logic [63:0] g2;
    logic [63:0] r;
    bt = '{default: '0};
    case (op)
      OP_SAMPLE: begin
        if (mtr_active) begin
          v = smp;
          if (v > 32768) v = 32768;
          else if (v < -32768) v = -32768;
          if (v < 0) v = -v;
          mag = v;
          if (mtr_period < PERIOD_CAP) begin
            mtr_sum += mag * mag;
            mtr_period++;
          end
          cap_lim = (mtr_limit < STORE_DEPTH) ? mtr_limit : STORE_DEPTH;
          if (mtr_count < cap_lim) begin
            mtr_store[mtr_count] = smp;
            mtr_count++;
          end else begin
            mtr_dropped = 1'b1;
          end
          if (pend) begin
            if (mtr_period == 0) begin
              mtr_level = '0;
            end else begin
              g2 = 64'(mtr_gain) * 64'(mtr_gain);
              r = root_floor((g2 * mtr_sum) / 64'(mtr_period));
              mtr_level = (r > 64'(FULL_SCALE)) ? FULL_SCALE : r[LEVEL_W-1:0];
            end
            mtr_sum = '0;
            mtr_period = 0;
            bt.updated = 1'b1;
          end
        end
      end
      OP_START: begin
        if (mtr_active) begin
          bt.serr = 1'b1;
        end else begin
          mtr_count = 0;
          mtr_dropped = 1'b0;
          mtr_level = '0;
          mtr_sum = '0;
          mtr_period = 0;
          mtr_active = 1'b1;
        end
      end
      OP_STOP: begin
        mtr_active = 1'b0;
        mtr_level = '0;
        mtr_sum = '0;
        mtr_period = 0;
      end
      default: begin
        if (int'(ridx) < mtr_count) begin
          bt.rdata = mtr_store[int'(ridx)];
          bt.rvalid = 1'b1;
        end
      end
    endcase
    bt.level = mtr_level;
    bt.total = mtr_count[CNT_W-1:0];
    bt.hit = mtr_dropped;
    bt.capturing = mtr_active;
    return bt;
  endfunction

  task automatic report_error(input string msg);
    if (err_cnt < 50) $display("%0t mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("beat %0d %s got 'h%0h, expected 'h%0h",
                             n_checked, name, got, want));
  endtask

  always @(posedge clk_i) begin : check_results
    meter_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_checked++;
      if (expected_beats.size() == 0) begin
        report_error($sformatf("beat %0d arrived with nothing expected", n_checked));
      end else begin
        want = expected_beats.pop_front();
        check_field("level", 32'(level_o), 32'(want.level));
        check_field("level_updated", 32'(level_updated_o), 32'(want.updated));
        check_field("read_data", 32'($unsigned(read_data_o)), 32'(want.rdata));
        check_field("read_valid", 32'(read_valid_o), 32'(want.rvalid));
        check_field("stored_total", 32'(stored_total_o), 32'(want.total));
        check_field("limit_hit", 32'(limit_hit_o), 32'(want.hit));
        check_field("capturing", 32'(capturing_o), 32'(want.capturing));
        check_field("start_error", 32'(start_error_o), 32'(want.serr));
        if (want.updated) n_updates++;
        if (want.rvalid) n_reads++;
      end
    end
  end

  // result side: long hold-off when requested, else random stalls
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycle_cnt, expected_beats.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input op_e op, input logic signed [SAMPLE_W-1:0] smp,
                           input logic pend, input logic [RIDX_W-1:0] ridx);
    bit was_active;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    sample_i <= smp;
    period_end_i <= pend;
    read_index_i <= ridx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    was_active = mtr_active;
    expected_beats.push_back(meter_step(op, smp, pend, ridx));
    n_items++;
    if (op != OP_SAMPLE || was_active) n_counted++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LEVEL_GAIN) mtr_gain = val[GAIN_W-1:0];
    else mtr_limit = int'(val);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(65536) - 32768;
      2: begin
        case ($urandom_range(3))
          0: return 131071;
          1: return -131072;
          2: return 32768;
          default: return -32768;
        endcase
      end
      default: return $urandom_range(511) - 256;
    endcase
  endfunction

  function automatic logic [RIDX_W-1:0] pick_index();
    if (mtr_count > 0 && $urandom_range(2) != 0) return $urandom_range(mtr_count - 1);
    return $urandom;
  endfunction

  task automatic capture_burst();
    int len;
    len = $urandom_range(40, 1);
    if (!mtr_active || $urandom_range(4) == 0)
      send_item(OP_START, rand_sample(), $urandom_range(1), $urandom);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) < 8)
        send_item(OP_SAMPLE, rand_sample(), (i == len - 1) || ($urandom_range(7) == 0),
                  $urandom);
      else
        send_item(OP_READ, rand_sample(), $urandom_range(1), pick_index());
    end
    if ($urandom_range(3) != 0) send_item(OP_STOP, rand_sample(), $urandom_range(1), $urandom);
  endtask

  task automatic run_random(input int n);
    int goal;
    goal = n_counted + n;
    while (n_counted < goal) begin
      if ($urandom_range(9) < 7) begin
        capture_burst();
      end else begin
        repeat ($urandom_range(4, 1))
          send_item(op_e'($urandom_range(3)), $urandom, $urandom_range(1), $urandom);
      end
    end
  endtask

  task automatic test_idle_ops();
    send_item(OP_SAMPLE, 1234, 1'b1, 0);
    send_item(OP_STOP, 0, 1'b0, 0);
    send_item(OP_READ, 0, 1'b0, 0);
  endtask

  task automatic test_capture_ops();
    send_item(OP_START, 0, 1'b0, 0);
    send_item(OP_START, 0, 1'b0, 0);
    send_item(OP_SAMPLE, 131071, 1'b0, 0);
    send_item(OP_SAMPLE, -131072, 1'b0, 0);
    send_item(OP_SAMPLE, 32768, 1'b0, 0);
    send_item(OP_SAMPLE, -32768, 1'b1, 0);
    send_item(OP_SAMPLE, 1, 1'b1, 0);
    send_item(OP_READ, 0, 1'b0, 0);
    send_item(OP_READ, 0, 1'b0, 4);
    send_item(OP_READ, 0, 1'b0, 5);
    send_item(OP_READ, 0, 1'b0, 16'hFFFF);
    send_item(OP_STOP, 0, 1'b0, 0);
    send_item(OP_READ, 0, 1'b0, 1);
  endtask

  task automatic test_gain_extremes();
    wait_idle();
    write_reg(REG_LEVEL_GAIN, 255);
    send_item(OP_START, 0, 1'b0, 0);
    send_item(OP_SAMPLE, -32768, 1'b1, 0);
    wait_idle();
    write_reg(REG_LEVEL_GAIN, 0);
    send_item(OP_SAMPLE, 32767, 1'b1, 0);
    send_item(OP_STOP, 0, 1'b0, 0);
  endtask

  task automatic test_store_limit();
    wait_idle();
    write_reg(REG_LEVEL_GAIN, GAIN_RST);
    write_reg(REG_SAMPLE_LIMIT, 0);
    send_item(OP_START, 0, 1'b0, 0);
    send_item(OP_SAMPLE, 1000, 1'b1, 0);
    wait_idle();
    write_reg(REG_SAMPLE_LIMIT, 2);
    send_item(OP_SAMPLE, -5, 1'b0, 0);
    send_item(OP_SAMPLE, 77, 1'b0, 0);
    send_item(OP_SAMPLE, -2000, 1'b1, 0);
    send_item(OP_READ, 0, 1'b0, 1);
    send_item(OP_READ, 0, 1'b0, 2);
    send_item(OP_STOP, 0, 1'b0, 0);
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(OP_START, 0, 1'b0, 0);
    hold_cycles = 300;
    repeat (40) send_item(OP_SAMPLE, rand_sample(), $urandom_range(7) == 0, 0);
    send_item(OP_STOP, 0, 1'b0, 0);
  endtask

  task automatic test_random_traffic();
    wait_idle();
    write_reg(REG_LEVEL_GAIN, 255);
    write_reg(REG_SAMPLE_LIMIT, LIMIT_RST);
    send_idle_pct = 26;
    recv_idle_pct = 70;
    run_random(110);
    wait_idle();
    write_reg(REG_LEVEL_GAIN, 1);
    write_reg(REG_SAMPLE_LIMIT, 7);
    send_idle_pct = 70;
    recv_idle_pct = 26;
    run_random(110);
    wait_idle();
    write_reg(REG_LEVEL_GAIN, 37);
    write_reg(REG_SAMPLE_LIMIT, 20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(110);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_idle_ops();
    test_capture_ops();
    test_gain_extremes();
    test_store_limit();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("%0d input beats sent, %0d results checked: %0d level updates, %0d valid reads",
             n_items, n_checked, n_updates, n_reads);
    $display("gain 0..255, store limits 0, 2, 7, 20 and default, long output stall");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
